>>> rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

   localparam int CFG_W      = 16;
   localparam int DIST_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int PHASE_W    = 2;
   localparam int COUNT_WIDTH_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_LIMIT    = 2'd2;

   localparam logic [CFG_W-1:0] TRIGGER_TICKS_RST = 16'd100;
   localparam logic [CFG_W-1:0] RISE_LIMIT_RST    = 16'd50000;
   localparam logic [CFG_W-1:0] FALL_LIMIT_RST    = 16'd30000;

   localparam logic [DIST_W-1:0] DIST_TIMEOUT = 16'hFFFF;

   // measurement phases
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_TRIG = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RISE = 2'd2;
   localparam logic [PHASE_W-1:0] PH_FALL = 2'd3;

   // distance = width * 343 / 4000, done as width * RECIP >> RECIP_SHIFT.
   // Widths of 2^20 and above always saturate, so the product only needs
   // SCALE_W bits of width; the rounding error stays below one count there.
   localparam int SCALE_W      = 20;
   localparam int RECIP_SHIFT  = 32;
   localparam int RECIP_W      = 29;
   localparam longint DIST_MUL = 343;
   localparam longint DIST_DIV = 4000;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((DIST_MUL * (64'd1 << RECIP_SHIFT) + DIST_DIV - 1) / DIST_DIV);
   localparam int PROD_W = SCALE_W + RECIP_W;
   localparam int QUOT_W = PROD_W - RECIP_SHIFT;

   typedef struct packed {
      logic [CFG_W-1:0] trigger_ticks;
      logic [CFG_W-1:0] rise_limit;
      logic [CFG_W-1:0] fall_limit;
   } cfg_type;

   typedef struct packed {
      logic trigger;
      logic done_res;
      logic timed_out;
   } flags_type;

endpackage

>>> rtl/uer_if.sv
`timescale 1ns / 1ps

interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo;

   modport source (output valid, output start_req, output echo, input ready);
   modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_rsp_if;
   logic        valid;
   logic        ready;
   logic        trigger;
   logic        done_res;
   logic        timed_out;
   logic [15:0] range_cm;

   modport source (output valid, output trigger, output done_res, output timed_out,
                   output range_cm, input ready);
   modport sink   (input valid, input trigger, input done_res, input timed_out,
                   input range_cm, output ready);
endinterface

interface uer_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/uer_ctrl.sv
`timescale 1ns / 1ps

module uer_ctrl
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   adv,
   input  logic                   in_vld,
   input  logic                   in_start,
   input  logic                   in_echo,
   output logic                   mid_vld,
   output flags_type              mid_flags,
   output logic [COUNT_WIDTH-1:0] mid_width
);

   localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] rise_ff, rise_in;
   logic                   echo_prev_ff;
   logic                   mid_vld_ff;
   flags_type              mid_flags_ff, flags_in;
   logic [COUNT_WIDTH-1:0] mid_width_ff, width_in;
   logic [CMP_W-1:0]       c_ext;
   logic                   rising, falling, step;

   assign step    = in_vld && adv;
   assign rising  = in_echo && !echo_prev_ff;
   assign falling = !in_echo && echo_prev_ff;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rise_in  = rise_ff;
      flags_in = '0;
      width_in = '0;

      if (phase_in == PH_IDLE && in_start) begin
         cnt_in   = '0;
         phase_in = PH_TRIG;
      end
      c_ext = CMP_W'(cnt_in);

      if (phase_in == PH_TRIG) begin
         if (c_ext < CMP_W'(cfg.trigger_ticks)) flags_in.trigger = 1'b1;
         else phase_in = PH_RISE;
      end

      // an edge wins over the limit on the same tick
      if (phase_in == PH_RISE) begin
         if (rising) begin
            rise_in  = cnt_in;
            phase_in = PH_FALL;
         end else if (c_ext > CMP_W'(cfg.rise_limit)) begin
            flags_in.done_res  = 1'b1;
            flags_in.timed_out = 1'b1;
            phase_in           = PH_IDLE;
         end
      end else if (phase_in == PH_FALL) begin
         if (falling) begin
            width_in          = cnt_in - rise_ff;
            flags_in.done_res = 1'b1;
            phase_in          = PH_IDLE;
         end else if (c_ext > CMP_W'(cfg.fall_limit)) begin
            flags_in.done_res  = 1'b1;
            flags_in.timed_out = 1'b1;
            phase_in           = PH_IDLE;
         end
      end

      if (phase_in != PH_IDLE || flags_in.done_res) cnt_in = cnt_in + COUNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         rise_ff      <= '0;
         echo_prev_ff <= 1'b0;
         mid_vld_ff   <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            rise_ff      <= rise_in;
            echo_prev_ff <= in_echo;
         end
         if (adv) mid_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_flags_ff <= flags_in;
         mid_width_ff <= width_in;
      end
   end

   assign mid_vld   = mid_vld_ff;
   assign mid_flags = mid_flags_ff;
   assign mid_width = mid_width_ff;

endmodule

>>> rtl/uer_scale.sv
`timescale 1ns / 1ps

module uer_scale
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   mid_vld,
   input  flags_type              mid_flags,
   input  logic [COUNT_WIDTH-1:0] mid_width,
   output logic                   out_vld,
   output flags_type              out_flags,
   output logic [DIST_W-1:0]      out_dist
);

   logic [SCALE_W-1:0] w_lo;
   logic               w_hi;
   logic [PROD_W-1:0]  prod;
   logic [QUOT_W-1:0]  quot;
   logic [DIST_W-1:0]  dist_in;
   logic               out_vld_ff;
   flags_type          out_flags_ff;
   logic [DIST_W-1:0]  out_dist_ff;

   generate
      if (COUNT_WIDTH > SCALE_W) begin : g_wide
         assign w_hi = |mid_width[COUNT_WIDTH-1:SCALE_W];
         assign w_lo = mid_width[SCALE_W-1:0];
      end else begin : g_narrow
         assign w_hi = 1'b0;
         assign w_lo = SCALE_W'(mid_width);
      end
   endgenerate

   assign prod = PROD_W'(w_lo) * PROD_W'(RECIP);
   assign quot = prod[PROD_W-1:RECIP_SHIFT];

   always_comb begin
      if (mid_flags.timed_out) dist_in = DIST_TIMEOUT;
      else if (!mid_flags.done_res) dist_in = '0;
      else if (w_hi || quot > QUOT_W'(DIST_TIMEOUT)) dist_in = DIST_TIMEOUT;
      else dist_in = quot[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= mid_vld;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_flags_ff <= mid_flags;
         out_dist_ff  <= dist_in;
      end
   end

   assign out_vld   = out_vld_ff;
   assign out_flags = out_flags_ff;
   assign out_dist  = out_dist_ff;

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic ranging controller, one item per microsecond tick.
// req: start_req and the sampled echo level for one tick. Every accepted
//   tick gives exactly one rsp item, in order.
// rsp: trigger level for the tick, done_res/timed_out when a measurement
//   ends, range_cm = width*343/4000 (65535 on timeout or overflow).
// csr: register writes, index 0 trigger_ticks, 1 rise_limit, 2 fall_limit;
//   other indexes are dropped. Always ready; write only while idle.
// Path: an accepted tick passes the input register, the phase/counter
//   stage and the distance multiply stage, then is held on rsp until taken.
// Throughput: one tick per cycle while rsp does not stall; the phase and
//   counter update for a tick is done in the control stage.
// Reset: phase idle, counter, rise time and echo history cleared, registers
//   back to 100 / 50000 / 30000; pipeline empty.
// Stall: the three stages advance together; while a result waits with
//   rsp.ready low the pipeline holds and req.ready drops.
module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   uer_req_if.sink   req,
   uer_rsp_if.source rsp,
   uer_csr_if.sink   csr
);

   cfg_type                cfg_ff;
   logic                   in_vld_ff;
   logic                   in_start_ff;
   logic                   in_echo_ff;
   logic                   adv;
   logic                   mid_vld;
   flags_type              mid_flags;
   logic [COUNT_WIDTH-1:0] mid_width;
   logic                   out_vld;
   flags_type              out_flags;
   logic [DIST_W-1:0]      out_dist;

   assign adv       = !out_vld || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RST;
         cfg_ff.rise_limit    <= RISE_LIMIT_RST;
         cfg_ff.fall_limit    <= FALL_LIMIT_RST;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            REG_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr.data;
            REG_RISE_LIMIT:    cfg_ff.rise_limit    <= csr.data;
            REG_FALL_LIMIT:    cfg_ff.fall_limit    <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else if (adv) in_vld_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_start_ff <= req.start_req;
         in_echo_ff  <= req.echo;
      end
   end

   uer_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .adv       (adv),
      .in_vld    (in_vld_ff),
      .in_start  (in_start_ff),
      .in_echo   (in_echo_ff),
      .mid_vld   (mid_vld),
      .mid_flags (mid_flags),
      .mid_width (mid_width)
   );

   uer_scale #(.COUNT_WIDTH(COUNT_WIDTH)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .mid_vld   (mid_vld),
      .mid_flags (mid_flags),
      .mid_width (mid_width),
      .out_vld   (out_vld),
      .out_flags (out_flags),
      .out_dist  (out_dist)
   );

   assign rsp.valid     = out_vld;
   assign rsp.trigger   = out_flags.trigger;
   assign rsp.done_res  = out_flags.done_res;
   assign rsp.timed_out = out_flags.timed_out;
   assign rsp.range_cm  = out_dist;

   // a timeout always ends the measurement with the saturated distance
   a_timeout_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.timed_out |-> rsp.done_res && rsp.range_cm == DIST_TIMEOUT)
      else $error("timeout result without done or full-scale distance");

   // trigger is only driven while no edge is being waited for
   a_trigger_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.trigger && rsp.done_res))
      else $error("trigger and done on the same tick");

   // with the receiver taking, an accepted tick passes the input, control and scale registers to the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) ##1 rsp.ready ##1 rsp.ready |=> rsp.valid)
      else $error("accepted tick did not reach the output");

endmodule

>>> dv/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb
   import uer_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 1_500_000;

   typedef struct packed {
      flags_type             flags;
      logic [DIST_W-1:0]     range_cm;
   } tick_result_type;

   class range_scoreboard;
      cfg_type                      cfg;
      logic [PHASE_W-1:0]           phase;
      logic [COUNT_WIDTH_DEF-1:0]   count;
      logic [COUNT_WIDTH_DEF-1:0]   rise_at;
      bit                           echo_prev;
      tick_result_type              expected_ticks[$];
      int                           errors;

      function new();
         cfg.trigger_ticks = TRIGGER_TICKS_RST;
         cfg.rise_limit    = RISE_LIMIT_RST;
         cfg.fall_limit    = FALL_LIMIT_RST;
         phase     = PH_IDLE;
         count     = '0;
         rise_at   = '0;
         echo_prev = 1'b0;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_TRIGGER_TICKS: cfg.trigger_ticks = value;
            REG_RISE_LIMIT:    cfg.rise_limit    = value;
            REG_FALL_LIMIT:    cfg.fall_limit    = value;
            default: ;
         endcase
      endfunction

      // one accepted tick: advance the ranging state and queue its result
      function void note_tick(bit start, bit echo_in);
         tick_result_type              r;
         logic [COUNT_WIDTH_DEF-1:0]   c;
         logic [COUNT_WIDTH_DEF-1:0]   width;
         bit                           rising;
         bit                           falling;
         r       = '0;
         rising  = echo_in && !echo_prev;
         falling = !echo_in && echo_prev;
         if (phase == PH_IDLE && start) begin
            count = '0;
            phase = PH_TRIG;
         end
         c = count;
         if (phase == PH_TRIG) begin
            if (c < cfg.trigger_ticks) r.flags.trigger = 1'b1;
            else phase = PH_RISE;
         end
         // edge wins over the limit on the same tick
         if (phase == PH_RISE) begin
            if (rising) begin
               rise_at = c;
               phase   = PH_FALL;
            end else if (c > cfg.rise_limit) begin
               r.flags.done_res  = 1'b1;
               r.flags.timed_out = 1'b1;
               r.range_cm        = DIST_TIMEOUT;
               phase             = PH_IDLE;
            end
         end else if (phase == PH_FALL) begin
            if (falling) begin
               width            = c - rise_at;
               r.flags.done_res = 1'b1;
               r.range_cm       = DIST_W'((longint'(width) * DIST_MUL) / DIST_DIV);
               phase            = PH_IDLE;
            end else if (c > cfg.fall_limit) begin
               r.flags.done_res  = 1'b1;
               r.flags.timed_out = 1'b1;
               r.range_cm        = DIST_TIMEOUT;
               phase             = PH_IDLE;
            end
         end
         if (phase != PH_IDLE || r.flags.done_res) count = c + 1'b1;
         echo_prev = echo_in;
         expected_ticks.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR @%0t: %s", $time, msg);
      endtask

      task check_result(tick_result_type got);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            report("result transfer with no tick outstanding");
            return;
         end
         want = expected_ticks.pop_front();
         if (got.flags.trigger !== want.flags.trigger)
            report($sformatf("trigger %b, expected %b", got.flags.trigger,
                             want.flags.trigger));
         if (got.flags.done_res !== want.flags.done_res)
            report($sformatf("done_res %b, expected %b", got.flags.done_res,
                             want.flags.done_res));
         if (got.flags.timed_out !== want.flags.timed_out)
            report($sformatf("timed_out %b, expected %b", got.flags.timed_out,
                             want.flags.timed_out));
         if (got.range_cm !== want.range_cm)
            report($sformatf("range_cm %0d, expected %0d", got.range_cm,
                             want.range_cm));
      endtask
   endclass

   logic clock;
   logic reset;

   uer_req_if req();
   uer_rsp_if rsp();
   uer_csr_if csr();

   ultrasonic_echo_ranger dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   range_scoreboard sb = new();
   tick_result_type seen_tick;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              ticks_sent    = 0;
   int              cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         seen_tick = {rsp.trigger, rsp.done_res, rsp.timed_out, rsp.range_cm};
         sb.check_result(seen_tick);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // valid is left high after a transfer; the next call either re-drives it
   // or drops it for a gap, so it is never lowered and raised in one step
   task automatic send_tick(input bit s, input bit e);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.start_req <= s;
      req.echo      <= e;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      sb.note_tick(s, e);
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (csr.ready !== 1'b1) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // registers only change once the pipeline has drained
   task automatic configure(input logic [CFG_W-1:0] trig_ticks,
                            input logic [CFG_W-1:0] rise_lim,
                            input logic [CFG_W-1:0] fall_lim);
      req.valid <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
      write_reg(REG_TRIGGER_TICKS, trig_ticks);
      write_reg(REG_RISE_LIMIT, rise_lim);
      write_reg(REG_FALL_LIMIT, fall_lim);
      write_reg(REG_UNMAPPED, CFG_W'($urandom));
      csr.valid <= 1'b0;
   endtask

   // toggling echo gives an edge every tick, so any wait ends quickly
   task automatic finish_busy();
      while (sb.phase != PH_IDLE) send_tick(1'($urandom_range(1)), !sb.echo_prev);
   endtask

   // start, then echo high for ticks [rise_k, rise_k + width) after the start tick
   task automatic measure(input int unsigned rise_k, input int unsigned width);
      int unsigned k;
      bit          s;
      bit          e;
      finish_busy();
      k = 0;
      while (k == 0 || sb.phase != PH_IDLE) begin
         if (k <= rise_k + width) e = (k >= rise_k) && (k < rise_k + width);
         else e = !sb.echo_prev;
         s = (k == 0) ? 1'b1 : 1'($urandom_range(1));
         send_tick(s, e);
         k++;
      end
   endtask

   function automatic logic [CFG_W-1:0] pick_limit();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return CFG_W'($urandom_range(1, 100));
      endcase
   endfunction

   task automatic run_phase(input int item_goal, input int sender_pct, input int receiver_pct);
      int unsigned trig;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      while (ticks_sent < item_goal) begin
         finish_busy();
         trig = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 16);
         configure(CFG_W'(trig), pick_limit(), pick_limit());
         repeat ($urandom_range(4, 9)) begin
            if ($urandom_range(4) == 0)
               repeat ($urandom_range(1, 4))
                  send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
               measure($urandom_range(0, trig + 40), $urandom_range(0, 60));
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.start_req <= 1'b0;
      req.echo      <= 1'b0;
      csr.valid     <= 1'b0;
      csr.index     <= REG_TRIGGER_TICKS;
      csr.data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      configure(16'd2, 16'd5, 16'd8);
      // echo edges while idle are ignored
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      measure(3, 2);     // clean pulse, zero distance
      measure(100, 0);   // no echo: rise wait times out
      measure(2, 100);   // echo stuck high: fall wait times out
      measure(1, 3);     // echo during trigger is not an edge

      run_phase(480, 32, 76);
      run_phase(960, 76, 32);
      run_phase(1450, 0, 0);

      // limits that never expire, long pulse
      finish_busy();
      configure(16'd1, 16'hFFFF, 16'hFFFF);
      measure(60, 200);

      req.valid <= 1'b0;
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
